// ----- rtl/pip_pkg.sv -----
// Package for the point-in-polygon crossing core: shared default coordinate width.
`default_nettype none

package pip_pkg;

    // Default coordinate width of the vertex and test point fields.
    localparam int unsigned COORD_BITS_DEF = 16;

endpackage : pip_pkg

`default_nettype wire

// ----- rtl/pip_edge_cross.sv -----
// Combinational test of whether one polygon edge crosses the leftward ray from the point.
`default_nettype none

module pip_edge_cross
    import pip_pkg::*;
#(
    parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic signed [COORD_BITS-1:0] i_xa,
    input  wire logic signed [COORD_BITS-1:0] i_ya,
    input  wire logic signed [COORD_BITS-1:0] i_xb,
    input  wire logic signed [COORD_BITS-1:0] i_yb,
    input  wire logic signed [COORD_BITS-1:0] i_px,
    input  wire logic signed [COORD_BITS-1:0] i_py,
    output logic                              o_cross
);

    localparam int unsigned DiffBits = COORD_BITS + 1;
    localparam int unsigned ProdBits = 2 * DiffBits;

    logic signed [DiffBits-1:0] x1, y1, x2, y2, px, py;
    logic signed [DiffBits-1:0] dx, dy, ey, ex;
    logic signed [ProdBits-1:0] lhs, rhs;
    logic                       straddles;

    always_comb begin
        // Order the endpoints so that the first one is the lower in y.
        if (i_ya < i_yb) begin
            x1 = DiffBits'(i_xa);
            y1 = DiffBits'(i_ya);
            x2 = DiffBits'(i_xb);
            y2 = DiffBits'(i_yb);
        end else begin
            x1 = DiffBits'(i_xb);
            y1 = DiffBits'(i_yb);
            x2 = DiffBits'(i_xa);
            y2 = DiffBits'(i_ya);
        end
        px = DiffBits'(i_px);
        py = DiffBits'(i_py);

        straddles = (y1 < py) && (py < y2);

        dx = x2 - x1;
        dy = y2 - y1;
        ey = py - y1;
        ex = px - x1;

        // With dy positive, x1 + ey*dx/dy < px is the same as ey*dx < ex*dy.
        lhs = ProdBits'(ey) * ProdBits'(dx);
        rhs = ProdBits'(ex) * ProdBits'(dy);

        o_cross = straddles && (lhs < rhs);
    end

endmodule : pip_edge_cross

`default_nettype wire

// ----- rtl/point_in_polygon_crossing_core.sv -----
// Top level of the even-odd ray-crossing point-in-polygon core.
//
//  Channel  | Direction | Handshake             | Payload
//  ---------+-----------+-----------------------+------------------------------------------
//  vertex   | in        | i_in_valid/o_in_ready | i_vertex_x/y, i_test_x/y, i_last_vertex
//  result   | out       | o_out_valid/i_out_ready | o_inside_res
//
// One vertex transaction is taken per clock cycle unless the input is stalled. Each vertex
// moves through an edge register, where the crossing tests of its edges are worked out, and
// a result register; a result is offered once its last vertex has passed through both.
// Reset is synchronous and active low; it empties both registers and starts a new polygon.
// A stall at the result port holds only a last vertex in the edge register, so other
// vertices keep flowing while a finished result waits to be taken.
`default_nettype none

module point_in_polygon_crossing_core
    import pip_pkg::*;
#(
    parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic signed [COORD_BITS-1:0] i_vertex_x,
    input  wire logic signed [COORD_BITS-1:0] i_vertex_y,
    input  wire logic signed [COORD_BITS-1:0] i_test_x,
    input  wire logic signed [COORD_BITS-1:0] i_test_y,
    input  wire logic                         i_last_vertex,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic                              o_inside_res
);

    // Polygon state, updated as each vertex transaction is accepted.
    logic                         r_mid;
    logic signed [COORD_BITS-1:0] r_first_x, r_first_y;
    logic signed [COORD_BITS-1:0] r_prev_x, r_prev_y;
    logic signed [COORD_BITS-1:0] r_held_x, r_held_y;

    // Edge register: the open edge (previous to current vertex) and the closing
    // edge (current to first vertex), together with the point they are tested against.
    logic                         r_s1_valid;
    logic                         r_s1_first;
    logic                         r_s1_last;
    logic signed [COORD_BITS-1:0] r_ea_xa, r_ea_ya, r_ea_xb, r_ea_yb;
    logic signed [COORD_BITS-1:0] r_eb_xa, r_eb_ya, r_eb_xb, r_eb_yb;
    logic signed [COORD_BITS-1:0] r_pt_x, r_pt_y;

    // Running parity and the result register.
    logic r_parity;
    logic r_out_valid;
    logic r_out_res;

    logic in_acc;
    logic s1_go;
    logic cross_a, cross_b;
    logic n_parity;
    logic n_out_valid;

    // The edge register moves on unless it holds a last vertex whose result has
    // nowhere to go because the result register is still full and stalled.
    assign s1_go      = r_s1_valid && (!r_s1_last || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_go;
    assign in_acc     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid <= 1'b0;
        end else if (in_acc) begin
            // The last vertex closes the polygon; the next one opens a new polygon.
            r_mid <= !i_last_vertex;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_prev_x <= i_vertex_x;
            r_prev_y <= i_vertex_y;
            if (!r_mid) begin
                r_first_x <= i_vertex_x;
                r_first_y <= i_vertex_y;
                r_held_x  <= i_test_x;
                r_held_y  <= i_test_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    // On the first vertex the first point and test point come straight from the
    // transaction, so that a one-vertex polygon closes on itself.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_first <= !r_mid;
            r_s1_last  <= i_last_vertex;
            r_ea_xa    <= r_prev_x;
            r_ea_ya    <= r_prev_y;
            r_ea_xb    <= i_vertex_x;
            r_ea_yb    <= i_vertex_y;
            r_eb_xa    <= i_vertex_x;
            r_eb_ya    <= i_vertex_y;
            r_eb_xb    <= r_mid ? r_first_x : i_vertex_x;
            r_eb_yb    <= r_mid ? r_first_y : i_vertex_y;
            r_pt_x     <= r_mid ? r_held_x : i_test_x;
            r_pt_y     <= r_mid ? r_held_y : i_test_y;
        end
    end

    pip_edge_cross #(
        .COORD_BITS (COORD_BITS)
    ) u_edge_open (
        .i_xa    (r_ea_xa),
        .i_ya    (r_ea_ya),
        .i_xb    (r_ea_xb),
        .i_yb    (r_ea_yb),
        .i_px    (r_pt_x),
        .i_py    (r_pt_y),
        .o_cross (cross_a)
    );

    pip_edge_cross #(
        .COORD_BITS (COORD_BITS)
    ) u_edge_close (
        .i_xa    (r_eb_xa),
        .i_ya    (r_eb_ya),
        .i_xb    (r_eb_xb),
        .i_yb    (r_eb_yb),
        .i_px    (r_pt_x),
        .i_py    (r_pt_y),
        .o_cross (cross_b)
    );

    // A first vertex has no open edge and restarts the parity from zero; the
    // closing edge only counts on a last vertex.
    always_comb begin
        n_parity = (r_s1_first ? 1'b0 : r_parity)
                 ^ (!r_s1_first && cross_a)
                 ^ (r_s1_last && cross_b);
        n_out_valid = (r_out_valid && !i_out_ready) || (s1_go && r_s1_last);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parity    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_go) begin
                r_parity <= n_parity;
            end
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1_last) begin
            r_out_res <= n_parity;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_inside_res = r_out_res;

endmodule : point_in_polygon_crossing_core

`default_nettype wire

// ----- rtl/pip_checker.sv -----
// Port-level checks for the point-in-polygon crossing core, bound to the top level.
`default_nettype none

module pip_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic o_in_ready,
    input wire logic o_out_valid,
    input wire logic i_out_ready,
    input wire logic o_inside_res
);

    // A result transaction, once offered, stays offered until it is taken.
    a_out_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result withdrawn before it was taken");

    // The stalled result keeps its value.
    a_out_stable : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_inside_res))
        else $error("stalled result changed");

    // The vertex side only stalls behind a full and stalled result register.
    a_stall_cause : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("vertex input stalled without a blocked result");

    // Reset leaves no result pending.
    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered straight after reset");

endmodule : pip_checker

bind point_in_polygon_crossing_core pip_checker u_pip_checker (.*);

`default_nettype wire
